// ===== rtl/gbs_pkg.sv =====
// Package for the gravity body stepper: field widths, stream packing offsets
// and the body record that the state memory holds. No dependencies.
`default_nettype none
package gbs_pkg;

    localparam int Q_W    = 40;  // signed Q24.16 position and velocity
    localparam int IDX_W  = 6;
    localparam int MASS_W = 32;
    localparam int G_W    = 32;

    // Input tdata: body_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y, load_mass.
    localparam int IN_IDX_LO  = 0;
    localparam int IN_PX_LO   = 6;
    localparam int IN_PY_LO   = 46;
    localparam int IN_VX_LO   = 86;
    localparam int IN_VY_LO   = 126;
    localparam int IN_MASS_LO = 166;
    localparam int IN_TDATA_W = 200;

    // Output tdata: out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y.
    localparam int OUT_IDX_LO  = 0;
    localparam int OUT_TDATA_W = 168;

    localparam logic [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic [G_W-1:0] GRAV_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [Q_W-1:0]    vel_y;
        logic [Q_W-1:0]    vel_x;
        logic [Q_W-1:0]    pos_y;
        logic [Q_W-1:0]    pos_x;
    } t_body;

endpackage
`default_nettype wire

// ===== rtl/gravity_body_step_top.sv =====
// Gravity body stepper top level: sequencer, shared multiplier, shared
// iterative divider and square root. Uses gbs_pkg and gbs_ram.
// A load is written to the state memory when accepted. After a tick is accepted,
// the pair loop runs three 96-step divisions and a 32-step square root per pair
// (a pair whose bodies coincide is skipped), fetches each body, steps it past every
// other body and writes it back, then sends each result while the output is free.
// One item is in work at a time. Reset is synchronous, active low: the state reads
// as zero, the constant returns to 1.0 and no result is pending.
`default_nettype none
module gravity_body_step_top #(
    parameter int BODIES = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // body_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y, load_mass, zero pad
    input  wire [199:0] s_axis_tdata,
    // kind
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y, zero pad
    output logic [167:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [31:0]  i_cfg_data
);

    localparam int AW = $clog2(BODIES);
    localparam logic [AW-1:0] LAST = AW'(BODIES - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_I, S_CAP_I, S_RD_J, S_OFF, S_SHIFT, S_PP, S_QQ,
        S_SQ_INIT, S_SQRT, S_RR, S_GM, S_DA_INIT, S_DIV_A, S_DX_INIT, S_DIV_X,
        S_DY_INIT, S_DIV_Y, S_MX, S_MY, S_VEL, S_POS, S_WB, S_OUT_RD, S_OUT_LD
    } t_state;

    t_state r_state;

    logic [31:0]       r_grav;
    logic [BODIES-1:0] r_valid;
    logic              r_rd_valid;
    logic [AW-1:0]     r_bi, r_bj, r_bo;

    gbs_pkg::t_body r_body_i;    // body i, updated across its pair loop
    gbs_pkg::t_body r_o_body;
    logic [AW-1:0]  r_o_idx;
    logic           r_o_valid, r_o_last;

    logic        r_dxneg, r_dyneg;
    logic [40:0] r_ax, r_ay;
    logic [31:0] r_mj;
    logic [3:0]  r_s;
    logic [30:0] r_p, r_q;
    logic [63:0] r_sq, r_rr;
    logic [63:0] r_v, r_res, r_bit;
    logic [71:0] r_prod;
    logic [39:0] r_a, r_mx;
    logic [24:0] r_ux;

    // Shared divider: restoring long division, one quotient bit a cycle.
    logic [95:0] r_dvd;
    logic [63:0] r_den, r_rem;
    logic [39:0] r_quo;
    logic        r_ovf;
    logic [6:0]  r_cnt;

    // Memory ports.
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    gbs_pkg::t_body ram_wdata, ram_q, rd_body;

    gbs_ram #(.WIDTH($bits(gbs_pkg::t_body)), .DEPTH(BODIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Entries never written read as zero.
    assign rd_body = r_rd_valid ? ram_q : '0;

    function automatic logic [39:0] sat40(input logic [41:0] v);
        logic [39:0] res;
        if (v[41:39] == 3'b000 || v[41:39] == 3'b111) begin
            res = v[39:0];
        end else if (v[41]) begin
            res = gbs_pkg::SAT_MIN;
        end else begin
            res = gbs_pkg::SAT_MAX;
        end
        return res;
    endfunction

    logic in_acc, load_acc, out_free, j_last;
    logic [AW-1:0] in_idx;
    gbs_pkg::t_body in_body;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign load_acc = in_acc && s_axis_tuser
                      && ({1'b0, s_axis_tdata[5:0]} < 7'(BODIES));
    assign in_idx   = AW'(s_axis_tdata[5:0]);
    assign out_free = !r_o_valid || m_axis_tready;
    assign j_last   = (r_bj == LAST);

    assign in_body.pos_x = s_axis_tdata[gbs_pkg::IN_PX_LO +: 40];
    assign in_body.pos_y = s_axis_tdata[gbs_pkg::IN_PY_LO +: 40];
    assign in_body.vel_x = s_axis_tdata[gbs_pkg::IN_VX_LO +: 40];
    assign in_body.vel_y = s_axis_tdata[gbs_pkg::IN_VY_LO +: 40];
    assign in_body.mass  = s_axis_tdata[gbs_pkg::IN_MASS_LO +: 32];

    // The sequencer writes a body back one state before any later read of the
    // store, so a read never meets a write to the same entry in flight.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = in_idx;
        ram_wdata = in_body;
        ram_re    = 1'b0;
        ram_raddr = r_bi;
        if (load_acc) begin
            ram_we = 1'b1;
        end else if (r_state == S_WB) begin
            ram_we    = 1'b1;
            ram_waddr = r_bi;
            ram_wdata = r_body_i;
        end
        unique case (r_state)
            S_RD_I:   ram_re = 1'b1;
            S_RD_J: begin
                ram_re    = (r_bj != r_bi);
                ram_raddr = r_bj;
            end
            S_OUT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_bo;
            end
            default:  ram_re = 1'b0;
        endcase
    end

    // Shared multiplier operands.
    logic [39:0] mul_a;
    logic [31:0] mul_b;
    always_comb begin
        unique case (r_state)
            S_PP:    begin mul_a = 40'(r_p); mul_b = 32'(r_p); end
            S_QQ:    begin mul_a = 40'(r_q); mul_b = 32'(r_q); end
            S_RR:    begin mul_a = 40'(r_res[31:0]); mul_b = r_res[31:0]; end
            S_GM:    begin mul_a = 40'(r_grav); mul_b = r_mj; end
            S_MX:    begin mul_a = r_a; mul_b = 32'(r_ux); end
            S_MY:    begin mul_a = r_a; mul_b = 32'(r_quo[24:0]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Offset magnitudes and the shift that brings both below 2^31.
    logic signed [40:0] dx, dy;
    logic [40:0] mag_or;
    logic [3:0]  s_w;
    always_comb begin
        dx = $signed({rd_body.pos_x[39], rd_body.pos_x})
             - $signed({r_body_i.pos_x[39], r_body_i.pos_x});
        dy = $signed({rd_body.pos_y[39], rd_body.pos_y})
             - $signed({r_body_i.pos_y[39], r_body_i.pos_y});
        mag_or = r_ax | r_ay;
        s_w = 4'd10;
        for (int k = 10; k >= 0; k--) begin
            if ((mag_or >> k) < 41'h0_8000_0000) begin
                s_w = 4'(k);
            end
        end
    end

    // Square root step.
    logic [63:0] sq_rb, n_v, n_res;
    logic        sq_ge;
    always_comb begin
        sq_rb = r_res + r_bit;
        sq_ge = (r_v >= sq_rb);
        n_v   = sq_ge ? r_v - sq_rb : r_v;
        n_res = sq_ge ? (r_res >> 1) + r_bit : (r_res >> 1);
    end

    // Divider step.
    logic [64:0] dv_t;
    logic        dv_ge;
    logic [63:0] n_rem;
    always_comb begin
        dv_t  = {r_rem, r_dvd[95]};
        dv_ge = (dv_t >= {1'b0, r_den});
        n_rem = dv_ge ? 64'(dv_t - {1'b0, r_den}) : dv_t[63:0];
    end

    logic [39:0] a_sat;
    assign a_sat = (r_ovf || r_quo[39]) ? gbs_pkg::SAT_MAX : r_quo;

    logic [5:0]  k_shift;
    assign k_shift = 6'd32 - {1'b0, r_s, 1'b0};

    // Velocity and position updates.
    logic [39:0] my_w;
    logic signed [41:0] dvx, dvy;
    logic [39:0] vx_new, vy_new, px_new, py_new;
    always_comb begin
        my_w   = r_prod[63:24];
        dvx    = r_dxneg ? -$signed({2'b00, r_mx}) : $signed({2'b00, r_mx});
        dvy    = r_dyneg ? -$signed({2'b00, my_w}) : $signed({2'b00, my_w});
        vx_new = sat40(42'($signed({{2{r_body_i.vel_x[39]}}, r_body_i.vel_x}) + dvx));
        vy_new = sat40(42'($signed({{2{r_body_i.vel_y[39]}}, r_body_i.vel_y}) + dvy));
        px_new = sat40({{2{r_body_i.pos_x[39]}}, r_body_i.pos_x}
                       + {{2{r_body_i.vel_x[39]}}, r_body_i.vel_x});
        py_new = sat40({{2{r_body_i.pos_y[39]}}, r_body_i.pos_y}
                       + {{2{r_body_i.vel_y[39]}}, r_body_i.vel_y});
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 72'(mul_a) * 72'(mul_b);
        if (ram_re) begin
            r_rd_valid <= r_valid[ram_raddr];
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_grav    <= gbs_pkg::GRAV_RESET;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
            r_bi      <= '0;
            r_bj      <= '0;
            r_bo      <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_grav <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            // The load state sets the output itself when the slot is free.
            if (m_axis_tready && r_state != S_OUT_LD) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !s_axis_tuser) begin
                        r_bi    <= '0;
                        r_state <= S_RD_I;
                    end
                end
                S_RD_I: r_state <= S_CAP_I;
                S_CAP_I: begin
                    r_body_i <= rd_body;
                    r_bj     <= '0;
                    r_state  <= S_RD_J;
                end
                S_RD_J: begin
                    if (r_bj != r_bi) begin
                        r_state <= S_OFF;
                    end else if (j_last) begin
                        r_state <= S_WB;
                    end else begin
                        r_bj <= r_bj + 1'b1;
                    end
                end
                S_OFF: begin
                    r_dxneg <= dx[40];
                    r_dyneg <= dy[40];
                    r_ax    <= dx[40] ? 41'(-dx) : 41'(dx);
                    r_ay    <= dy[40] ? 41'(-dy) : 41'(dy);
                    r_mj    <= rd_body.mass;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_s     <= s_w;
                    r_p     <= 31'(r_ax >> s_w);
                    r_q     <= 31'(r_ay >> s_w);
                    r_state <= S_PP;
                end
                S_PP: r_state <= S_QQ;
                S_QQ: begin
                    r_sq    <= r_prod[63:0];
                    r_state <= S_SQ_INIT;
                end
                S_SQ_INIT: begin
                    r_v     <= r_sq + r_prod[63:0];
                    r_res   <= '0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_cnt   <= 7'd32;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_v   <= n_v;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_RR;
                    end
                end
                S_RR: begin
                    // Coincident bodies: the pair is skipped.
                    if (r_res == '0) begin
                        if (j_last) begin
                            r_state <= S_WB;
                        end else begin
                            r_bj    <= r_bj + 1'b1;
                            r_state <= S_RD_J;
                        end
                    end else begin
                        r_state <= S_GM;
                    end
                end
                S_GM: begin
                    r_rr    <= r_prod[63:0];
                    r_state <= S_DA_INIT;
                end
                S_DA_INIT: begin
                    r_dvd   <= 96'(r_prod[63:0]) << k_shift;
                    r_den   <= r_rr;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= 7'd96;
                    r_state <= S_DIV_A;
                end
                S_DX_INIT, S_DY_INIT: begin
                    if (r_state == S_DX_INIT) begin
                        r_a   <= a_sat;
                        r_dvd <= {41'b0, r_p, 24'b0};
                    end else begin
                        r_ux  <= r_quo[24:0];
                        r_dvd <= {41'b0, r_q, 24'b0};
                    end
                    r_den   <= {32'b0, r_res[31:0]};
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= 7'd96;
                    r_state <= (r_state == S_DX_INIT) ? S_DIV_X : S_DIV_Y;
                end
                S_DIV_A, S_DIV_X, S_DIV_Y: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[94:0], 1'b0};
                    r_quo <= {r_quo[38:0], dv_ge};
                    r_ovf <= r_ovf | r_quo[39];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 7'd1) begin
                        priority case (r_state)
                            S_DIV_A: r_state <= S_DX_INIT;
                            S_DIV_X: r_state <= S_DY_INIT;
                            default: r_state <= S_MX;
                        endcase
                    end
                end
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_mx    <= r_prod[63:24];
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    r_body_i.vel_x <= vx_new;
                    r_body_i.vel_y <= vy_new;
                    r_state        <= S_POS;
                end
                S_POS: begin
                    r_body_i.pos_x <= px_new;
                    r_body_i.pos_y <= py_new;
                    if (j_last) begin
                        r_state <= S_WB;
                    end else begin
                        r_bj    <= r_bj + 1'b1;
                        r_state <= S_RD_J;
                    end
                end
                S_WB: begin
                    if (r_bi == LAST) begin
                        r_bo    <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_bi    <= r_bi + 1'b1;
                        r_state <= S_RD_I;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_body  <= rd_body;
                        r_o_idx   <= r_bo;
                        r_o_last  <= (r_bo == LAST);
                        if (r_bo == LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_bo    <= r_bo + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {2'b00, r_o_body.vel_y, r_o_body.vel_x, r_o_body.pos_y,
                            r_o_body.pos_x, gbs_pkg::IDX_W'(r_o_idx)};

endmodule
`default_nettype wire

// ===== rtl/gbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gbs_checker.sv =====
// Port-level checker for the gravity body stepper, bound to the top level.
// Uses gbs_pkg for the output field layout.
`default_nettype none
module gbs_checker #(
    parameter int BODIES = 2
) (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [199:0] s_axis_tdata,
    input wire         s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [167:0] m_axis_tdata,
    input wire         m_axis_tlast,
    input wire         i_cfg_valid,
    input wire         o_cfg_ready,
    input wire [31:0]  i_cfg_data
);

    logic [gbs_pkg::IDX_W-1:0] out_idx;
    assign out_idx = m_axis_tdata[gbs_pkg::OUT_IDX_LO +: gbs_pkg::IDX_W];

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // The marked result belongs to the highest body.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> out_idx == gbs_pkg::IDX_W'(BODIES - 1))
        else $error("last result on wrong body");

    // No new request is taken while a tick still has results to send.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("request taken in the middle of a tick");

    // A load request produces no result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("load produced a result");

endmodule

bind gravity_body_step_top gbs_checker #(.BODIES(BODIES)) u_gbs_checker (.*);
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for gravity_body_step_top: streams load and tick requests, predicts
// every body state in a model of its own and checks each result. Uses gbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int BODIES   = 2;
    localparam int N_RANDOM = 330;
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;
    localparam longint LIMIT   = 3_000_000;
    localparam int RX_HOLD_CYCLES = 3000;

    typedef struct packed {
        logic       kind;
        logic [5:0] idx;
        logic signed [gbs_pkg::Q_W-1:0] px, py, vx, vy;
        logic [gbs_pkg::MASS_W-1:0] mass;
    } t_request;

    typedef struct packed {
        logic [5:0] idx;
        logic signed [gbs_pkg::Q_W-1:0] px, py, vx, vy;
        logic last;
    } t_state_out;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    wire          s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 0;
    wire  [167:0] m_axis_tdata;
    wire          m_axis_tlast;
    logic         i_cfg_valid = 0;
    wire          o_cfg_ready;
    logic [31:0]  i_cfg_data = '0;

    gravity_body_step_top #(.BODIES(BODIES)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Body model.
    logic signed [gbs_pkg::Q_W-1:0] m_px [BODIES], m_py [BODIES];
    logic signed [gbs_pkg::Q_W-1:0] m_vx [BODIES], m_vy [BODIES];
    logic [gbs_pkg::MASS_W-1:0]     m_mass [BODIES];
    logic [gbs_pkg::G_W-1:0]        m_grav;

    t_request   pending_requests [$];
    t_state_out expected_states [$];
    int         n_errors = 0;
    longint     cycle = 0;
    bit         stim_done = 0;
    bit         hold_sender = 0;
    bit         rx_hold_req = 0;
    bit         rx_hold_seen = 0;
    int         rx_hold = 0;

    function automatic logic signed [gbs_pkg::Q_W-1:0] sat_sum(
        logic signed [gbs_pkg::Q_W-1:0] a, logic signed [gbs_pkg::Q_W-1:0] b);
        logic signed [gbs_pkg::Q_W:0] s;
        s = a + b;
        if (s > $signed({2'b00, {(gbs_pkg::Q_W-1){1'b1}}})) return gbs_pkg::SAT_MAX;
        if (s < $signed({2'b11, {(gbs_pkg::Q_W-1){1'b0}}})) return gbs_pkg::SAT_MIN;
        return s[gbs_pkg::Q_W-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // floor(num * 2^k / den), clipped to the largest position value.
    function automatic logic [63:0] accel_div(logic [63:0] num, logic [63:0] den, int k);
        logic [63:0] q, rem;
        logic [63:0] cap;
        cap = 64'h7F_FFFF_FFFF;
        q = num / den;
        rem = num % den;
        if (q > cap) return cap;
        for (int n = 0; n < k; n++) begin
            q <<= 1;
            if (rem >= den - rem) begin
                rem = rem - (den - rem);
                q |= 1;
            end else begin
                rem <<= 1;
            end
            if (q > cap) return cap;
        end
        return q;
    endfunction

    task automatic pull_body(int i, int j);
        logic signed [63:0] dx, dy, dvx, dvy;
        logic [63:0] ax, ay, p, q, r, a, ux, uy, mx, my;
        int s;
        dx = 64'(m_px[j]) - 64'(m_px[i]);
        dy = 64'(m_py[j]) - 64'(m_py[i]);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        s = 0;
        while (s < 40 && ((ax >> s) >= 64'h8000_0000 || (ay >> s) >= 64'h8000_0000)) s++;
        p = ax >> s;
        q = ay >> s;
        r = int_sqrt(p * p + q * q);
        if (r == 0) return;
        a = accel_div(64'(m_grav) * 64'(m_mass[j]), r * r, 2 * s < 32 ? 32 - 2 * s : 0);
        ux = (p << 24) / r;
        uy = (q << 24) / r;
        mx = (a * ux) >> 24;
        my = (a * uy) >> 24;
        dvx = dx < 0 ? -$signed(mx) : $signed(mx);
        dvy = dy < 0 ? -$signed(my) : $signed(my);
        m_vx[i] = sat_sum(m_vx[i], dvx[gbs_pkg::Q_W-1:0]);
        m_vy[i] = sat_sum(m_vy[i], dvy[gbs_pkg::Q_W-1:0]);
        m_px[i] = sat_sum(m_px[i], m_vx[i]);
        m_py[i] = sat_sum(m_py[i], m_vy[i]);
    endtask

    task automatic predict_request(t_request rq);
        t_state_out o;
        if (rq.kind == KIND_LOAD) begin
            if (rq.idx < BODIES) begin
                m_px[rq.idx] = rq.px;
                m_py[rq.idx] = rq.py;
                m_vx[rq.idx] = rq.vx;
                m_vy[rq.idx] = rq.vy;
                m_mass[rq.idx] = rq.mass;
            end
            return;
        end
        for (int i = 0; i < BODIES; i++)
            for (int j = 0; j < BODIES; j++)
                if (i != j) pull_body(i, j);
        for (int i = 0; i < BODIES; i++) begin
            o.idx = 6'(i);
            o.px = m_px[i];
            o.py = m_py[i];
            o.vx = m_vx[i];
            o.vy = m_vy[i];
            o.last = (i == BODIES - 1);
            expected_states.push_back(o);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
        n_errors++;
    endtask

    // Sender: bursts with random gaps.
    int burst_left = 0, gap_left = 0;
    t_request cur_req;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_request(cur_req);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 0;
                end else if (pending_requests.size() > 0 && !hold_sender) begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tuser <= cur_req.kind;
                    s_axis_tdata <= {2'd0, cur_req.mass, cur_req.vy, cur_req.vx,
                                     cur_req.py, cur_req.px, cur_req.idx};
                    s_axis_tvalid <= 1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 6);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once it is requested.
    always @(posedge i_clk) begin
        if (rx_hold_req && !rx_hold_seen) begin
            rx_hold_seen <= 1;
            rx_hold <= RX_HOLD_CYCLES;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Receiver: stall pattern of its own plus the long hold-off.
    always @(posedge i_clk) begin
        t_state_out w;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_states.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
                end else begin
                    w = expected_states.pop_front();
                    if (m_axis_tdata[5:0] != w.idx) report_mismatch("index", m_axis_tdata[5:0], w.idx);
                    if (m_axis_tdata[45:6] != w.px) report_mismatch("pos_x", m_axis_tdata[45:6], w.px);
                    if (m_axis_tdata[85:46] != w.py) report_mismatch("pos_y", m_axis_tdata[85:46], w.py);
                    if (m_axis_tdata[125:86] != w.vx) report_mismatch("vel_x", m_axis_tdata[125:86], w.vx);
                    if (m_axis_tdata[165:126] != w.vy)
                        report_mismatch("vel_y", m_axis_tdata[165:126], w.vy);
                    if (m_axis_tlast != w.last) report_mismatch("last", m_axis_tlast, w.last);
                end
            end
            if (rx_hold > 0) begin
                m_axis_tready <= 0;
            end else if (cycle % 5000 < 2500) begin
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [gbs_pkg::Q_W-1:0] rand_q(int mode);
        logic signed [gbs_pkg::Q_W-1:0] v;
        case (mode)
            0: v = gbs_pkg::Q_W'({$urandom, $urandom});
            1: v = $signed(40'($urandom_range(0, 2000))) <<< 16;
            2: v = -($signed(40'($urandom_range(0, 2000))) <<< 16);
            default: v = $signed(40'($signed($urandom_range(0, 65535)) - 32768)) <<< 8;
        endcase
        return v;
    endfunction

    function automatic t_request make_load(int idx, logic signed [gbs_pkg::Q_W-1:0] px,
                                           logic signed [gbs_pkg::Q_W-1:0] py,
                                           logic signed [gbs_pkg::Q_W-1:0] vx,
                                           logic signed [gbs_pkg::Q_W-1:0] vy,
                                           logic [gbs_pkg::MASS_W-1:0] mass);
        t_request r;
        r.kind = KIND_LOAD;
        r.idx = 6'(idx);
        r.px = px; r.py = py; r.vx = vx; r.vy = vy; r.mass = mass;
        return r;
    endfunction

    function automatic t_request make_tick();
        t_request r;
        r = '0;
        r.kind = KIND_TICK;
        r.idx = 6'($urandom);
        r.px = gbs_pkg::Q_W'({$urandom, $urandom});
        r.mass = $urandom;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_states.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_grav(logic [31:0] g);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        m_grav = g;
    endtask

    initial begin
        logic [31:0] gsets [4];
        int m;
        m_grav = gbs_pkg::GRAV_RESET;
        for (int k = 0; k < BODIES; k++) begin
            m_px[k] = 0; m_py[k] = 0; m_vx[k] = 0; m_vy[k] = 0; m_mass[k] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: reset state tick, extremes, coincident bodies, zero mass,
        // ignored out-of-range loads.
        pending_requests.push_back(make_tick());
        pending_requests.push_back(make_load(0, gbs_pkg::SAT_MAX, gbs_pkg::SAT_MIN,
                                             gbs_pkg::SAT_MAX, gbs_pkg::SAT_MIN, '1));
        pending_requests.push_back(make_load(1, gbs_pkg::SAT_MIN, gbs_pkg::SAT_MAX,
                                             gbs_pkg::SAT_MIN, gbs_pkg::SAT_MAX, '1));
        pending_requests.push_back(make_tick());
        pending_requests.push_back(make_load(0, 40'sd0, 40'sd0, 40'sd0, 40'sd0, 32'd5));
        pending_requests.push_back(make_load(1, 40'sd0, 40'sd0, 40'sd0, 40'sd0, 32'd5));
        pending_requests.push_back(make_tick());
        pending_requests.push_back(make_load(1, 40'sd65536, -40'sd65536, 40'sd0, 40'sd0, 0));
        pending_requests.push_back(make_tick());
        pending_requests.push_back(make_load(63, gbs_pkg::SAT_MAX, gbs_pkg::SAT_MAX,
                                             gbs_pkg::SAT_MAX, gbs_pkg::SAT_MAX, '1));
        pending_requests.push_back(make_load(BODIES, 40'sd1, 40'sd1, 40'sd1, 40'sd1, 1));
        pending_requests.push_back(make_load(0, 40'sd1, 40'sd0, -40'sd1, 40'sd0, 32'd1));
        pending_requests.push_back(make_tick());
        pending_requests.push_back(make_tick());
        wait_drained();

        gsets[0] = 32'd0; gsets[1] = 32'hFFFF_FFFF;
        gsets[2] = 32'h0001_0000; gsets[3] = $urandom;
        for (int ph = 0; ph < 4; ph++) begin
            write_grav(gsets[ph]);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if ($urandom_range(0, 2) == 0) begin
                    pending_requests.push_back(make_tick());
                end else begin
                    m = $urandom_range(0, 3);
                    pending_requests.push_back(make_load(
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, BODIES - 1),
                        rand_q(m), rand_q(m), rand_q($urandom_range(0, 3)),
                        rand_q($urandom_range(0, 3)),
                        ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1000)));
                end
            end
            // Long receiver hold-off while ticks keep coming, in the second phase.
            if (ph == 1) rx_hold_req = 1;
            // Sender pauses until everything drained, in the third phase.
            if (ph == 2) begin
                while (pending_requests.size() > 40) @(posedge i_clk);
                hold_sender = 1;
                while (s_axis_tvalid || expected_states.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
